// ----- rtl/core/cvhull_pkg.sv -----
// Shared constants and types for the convex hull gift-wrap unit.
package cvhull_pkg;

	localparam int VIDX_W   = 6;
	localparam int STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK   = 2'd0;
	localparam status_t STATUS_FEW  = 2'd1;
	localparam status_t STATUS_DROP = 2'd2;
	localparam status_t STATUS_OPEN = 2'd3;

endpackage

// ----- rtl/core/cvhull_if.sv -----
// Point and hull vertex channel interfaces (valid/ready with payload).
interface cvhull_pt_if #(parameter int COORD_BITS = 16) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic                         last_point;

	modport source(output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink(input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

interface cvhull_vx_if #(parameter int COORD_BITS = 16) ();
	import cvhull_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [VIDX_W-1:0]            vertex_index;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         last_vertex;
	status_t                      status;

	modport source(output valid, output vertex_index, output vertex_x, output vertex_y,
		output last_vertex, output status, input ready);
	modport sink(input valid, input vertex_index, input vertex_x, input vertex_y,
		input last_vertex, input status, output ready);
endinterface

// ----- rtl/core/convex_hull_gift_wrap_unit.sv -----
// Convex hull (gift wrapping) unit: top level with point store, scan sequencer and output.
//
// Points load at one transaction per cycle, while the unit is loading, into a point RAM;
// a point beyond POINTS is dropped and flagged. The transaction carrying last_point starts
// the hull pass, during which, as while vertices leave, no point is taken. Each hull round
// compares every stored point against the candidate (RAM read, difference, multiply,
// compare, done one at a time on a single shared multiplier pair) and skips the pivot
// slot; a set with H hull vertices takes H + 1 rounds, the extra round being the one that
// finds the first vertex again. Vertices then leave from a hull RAM one transaction at a
// time, each read and registered and then held until the sink is ready. A set with a
// single point returns one transaction with status 1 in the cycle after loading.
module convex_hull_gift_wrap_unit #(
	parameter int POINTS     = 64,
	parameter int COORD_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	cvhull_pt_if.sink   pnt,
	cvhull_vx_if.source hull
);
	import cvhull_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int IDXW  = $clog2(POINTS);
	localparam int CNTW  = $clog2(POINTS + 1);
	localparam int PICKW = $clog2(POINTS + 2);
	localparam int DW    = CB + 2;
	localparam int PW    = 2 * DW;
	localparam int HW    = IDXW + 2 * CB;

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_ROUND  = 4'd1;
	localparam logic [3:0] ST_BEST   = 4'd2;
	localparam logic [3:0] ST_RD     = 4'd3;
	localparam logic [3:0] ST_DIFF   = 4'd4;
	localparam logic [3:0] ST_MUL    = 4'd5;
	localparam logic [3:0] ST_CMP    = 4'd6;
	localparam logic [3:0] ST_PICK   = 4'd7;
	localparam logic [3:0] ST_EMRD   = 4'd8;
	localparam logic [3:0] ST_EMWT   = 4'd9;
	localparam logic [3:0] ST_EMHOLD = 4'd10;

	logic [3:0]       state_q;
	logic [CNTW-1:0]  count_q;
	logic             ovf_q;
	logic             piv_vld_q;
	logic [PICKW-1:0] picks_q;
	logic [CNTW-1:0]  s_q;
	logic [PICKW-1:0] k_q;
	logic [PICKW-1:0] emit_q;
	logic             out_valid_q;

	logic [IDXW-1:0]       piv_slot_q;
	logic [IDXW-1:0]       best_q;
	logic [IDXW-1:0]       start_q;
	logic signed [CB-1:0]  least_x_q, least_y_q;
	logic signed [CB:0]    piv_x_q, piv_y_q;
	logic signed [CB-1:0]  bx_q, by_q, cx_q, cy_q;
	logic signed [DW-1:0]  d1_s1, d2_s1, d3_s1, d4_s1;
	logic signed [PW-1:0]  p_s2, q_s2;
	status_t               status_q;
	logic [VIDX_W-1:0]     out_idx_q;
	logic signed [CB-1:0]  out_x_q, out_y_q;
	logic                  out_last_q;
	status_t               out_status_q;

	logic                  accept;
	logic                  store;
	logic signed [CB-1:0]  lx_nxt, ly_nxt;
	logic [IDXW-1:0]       best_init;
	logic                  skip_s;
	logic                  scan_end;
	logic                  closed;
	logic [PICKW-1:0]      picks_nxt;

	logic                  pt_re;
	logic [IDXW-1:0]       pt_raddr;
	logic [2*CB-1:0]       pt_rdata;
	logic                  hl_we;
	logic [HW-1:0]         hl_rdata;

	assign accept    = pnt.valid && pnt.ready;
	assign store     = accept && (count_q < CNTW'(POINTS));
	assign pnt.ready = (state_q == ST_LOAD);

	assign lx_nxt = (store && (count_q == '0 || pnt.point_x < least_x_q)) ?
		pnt.point_x : least_x_q;
	assign ly_nxt = (store && (count_q == '0 || pnt.point_y < least_y_q)) ?
		pnt.point_y : least_y_q;

	assign best_init = (piv_vld_q && piv_slot_q == '0) ? IDXW'(1) : '0;
	assign scan_end  = (s_q >= count_q);
	assign skip_s    = piv_vld_q && (s_q[IDXW-1:0] == piv_slot_q);
	assign closed    = (picks_q != '0) && (best_q == start_q);
	assign picks_nxt = picks_q + PICKW'(1);

	assign pt_re    = (state_q == ST_ROUND) || (state_q == ST_RD && !scan_end && !skip_s);
	assign pt_raddr = (state_q == ST_ROUND) ? best_init : s_q[IDXW-1:0];
	assign hl_we    = (state_q == ST_PICK) && (picks_q < PICKW'(POINTS));

	cvhull_ram #(.WIDTH(2 * CB), .DEPTH(POINTS)) u_pt_ram (
		.clk  (clk),
		.we   (store),
		.waddr(count_q[IDXW-1:0]),
		.wdata({pnt.point_x, pnt.point_y}),
		.re   (pt_re),
		.raddr(pt_raddr),
		.rdata(pt_rdata)
	);

	cvhull_ram #(.WIDTH(HW), .DEPTH(POINTS)) u_hull_ram (
		.clk  (clk),
		.we   (hl_we),
		.waddr(picks_q[IDXW-1:0]),
		.wdata({best_q, bx_q, by_q}),
		.re   (state_q == ST_EMRD),
		.raddr(k_q[IDXW-1:0]),
		.rdata(hl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			piv_vld_q   <= 1'b0;
			picks_q     <= '0;
			s_q         <= '0;
			k_q         <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store) begin
							count_q <= count_q + CNTW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (pnt.last_point) begin
							if (count_q == '0) begin
								out_valid_q <= 1'b1;
								state_q     <= ST_EMHOLD;
							end else begin
								picks_q   <= '0;
								piv_vld_q <= 1'b0;
								state_q   <= ST_ROUND;
							end
						end
					end
				end
				ST_ROUND: begin
					s_q     <= CNTW'(best_init) + CNTW'(1);
					state_q <= ST_BEST;
				end
				ST_BEST: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (scan_end) begin
						state_q <= ST_PICK;
					end else if (skip_s) begin
						s_q <= s_q + CNTW'(1);
					end else begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					s_q     <= s_q + CNTW'(1);
					state_q <= ST_RD;
				end
				ST_PICK: begin
					picks_q   <= picks_nxt;
					piv_vld_q <= 1'b1;
					k_q       <= '0;
					if (closed) begin
						emit_q  <= picks_q;
						state_q <= ST_EMRD;
					end else if (picks_nxt == PICKW'(POINTS + 1)) begin
						emit_q  <= PICKW'(POINTS);
						state_q <= ST_EMRD;
					end else begin
						state_q <= ST_ROUND;
					end
				end
				ST_EMRD: begin
					state_q <= ST_EMWT;
				end
				ST_EMWT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMHOLD;
				end
				ST_EMHOLD: begin
					if (hull.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							count_q   <= '0;
							ovf_q     <= 1'b0;
							piv_vld_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							k_q     <= k_q + PICKW'(1);
							state_q <= ST_EMRD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (store) begin
					least_x_q <= lx_nxt;
					least_y_q <= ly_nxt;
				end
				piv_x_q <= $signed({lx_nxt[CB-1], lx_nxt}) - (CB + 1)'(1);
				piv_y_q <= $signed({ly_nxt[CB-1], ly_nxt}) - (CB + 1)'(1);
				out_idx_q    <= '0;
				out_x_q      <= '0;
				out_y_q      <= '0;
				out_last_q   <= 1'b1;
				out_status_q <= STATUS_FEW;
			end
			ST_ROUND: begin
				best_q <= best_init;
			end
			ST_BEST: begin
				bx_q <= pt_rdata[2*CB-1:CB];
				by_q <= pt_rdata[CB-1:0];
			end
			ST_DIFF: begin
				cx_q  <= pt_rdata[2*CB-1:CB];
				cy_q  <= pt_rdata[CB-1:0];
				d1_s1 <= $signed({{2{bx_q[CB-1]}}, bx_q}) - $signed({piv_x_q[CB], piv_x_q});
				d2_s1 <= $signed({{2{pt_rdata[CB-1]}}, pt_rdata[CB-1:0]})
					- $signed({piv_y_q[CB], piv_y_q});
				d3_s1 <= $signed({{2{by_q[CB-1]}}, by_q}) - $signed({piv_y_q[CB], piv_y_q});
				d4_s1 <= $signed({{2{pt_rdata[2*CB-1]}}, pt_rdata[2*CB-1:CB]})
					- $signed({piv_x_q[CB], piv_x_q});
			end
			ST_MUL: begin
				p_s2 <= PW'(d1_s1) * PW'(d2_s1);
				q_s2 <= PW'(d3_s1) * PW'(d4_s1);
			end
			ST_CMP: begin
				if (p_s2 > q_s2) begin
					best_q <= s_q[IDXW-1:0];
					bx_q   <= cx_q;
					by_q   <= cy_q;
				end
			end
			ST_PICK: begin
				if (picks_q == '0) begin
					start_q <= best_q;
				end
				piv_x_q    <= $signed({bx_q[CB-1], bx_q});
				piv_y_q    <= $signed({by_q[CB-1], by_q});
				piv_slot_q <= best_q;
				if (closed) begin
					status_q <= ovf_q ? STATUS_DROP : STATUS_OK;
				end else begin
					status_q <= STATUS_OPEN;
				end
			end
			ST_EMWT: begin
				out_idx_q    <= VIDX_W'(hl_rdata[HW-1 -: IDXW]);
				out_x_q      <= hl_rdata[2*CB-1:CB];
				out_y_q      <= hl_rdata[CB-1:0];
				out_last_q   <= (k_q + PICKW'(1) == emit_q);
				out_status_q <= status_q;
			end
			default: begin
			end
		endcase
	end

	assign hull.valid        = out_valid_q;
	assign hull.vertex_index = out_idx_q;
	assign hull.vertex_x     = out_x_q;
	assign hull.vertex_y     = out_y_q;
	assign hull.last_vertex  = out_last_q;
	assign hull.status       = out_status_q;

	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		pnt.ready |-> !hull.valid)
		else $error("point load enabled while a vertex is pending");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		hull.valid && hull.ready && hull.last_vertex |=> pnt.ready)
		else $error("final vertex taken but loading not resumed");

	a_picks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		picks_q <= PICKW'(POINTS + 1))
		else $error("hull pick count beyond bound");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(POINTS))
		else $error("point count beyond store depth");

	a_best_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PICK |-> CNTW'(best_q) < count_q)
		else $error("picked vertex outside loaded points");

endmodule

// ----- rtl/core/cvhull_ram.sv -----
// Generic single-clock RAM, one write port, one read port with registered data.
module cvhull_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
